### hdl/difficulty_retarget_compact_top_assert.svh
// Assertion macros used by the checker file of the retarget block.
`ifndef DIFFICULTY_RETARGET_COMPACT_TOP_ASSERT_SVH
`define DIFFICULTY_RETARGET_COMPACT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define DR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/dr_pkg.sv
// ----------------------------------------------------------------------------
// Retarget package
// Shared widths and the item record passed along the divider cell chain.
// ----------------------------------------------------------------------------
package dr_pkg;

    localparam int TGT_W     = 256;
    localparam int DIV_W     = 24;
    localparam int DIGIT_W   = 8;
    localparam int NUM_CELLS = TGT_W / DIGIT_W;

    localparam logic CFG_NOMINAL_SPAN = 1'b0;
    localparam logic CFG_LIMIT_BITS   = 1'b1;

    localparam logic [23:0] NOMINAL_SPAN_RST = 24'd1209600;
    localparam logic [31:0] LIMIT_BITS_RST   = 32'h1d00ffff;

    // Word holds the not yet consumed dividend bits at the top and the
    // quotient bits collected so far at the bottom.
    typedef struct packed {
        logic             vld;
        logic [TGT_W-1:0] word;
        logic [DIV_W-1:0] rem;
    } cell_t;

endpackage

### hdl/dr_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// Produces one quotient digit of a restoring division and hands the item on.
// ----------------------------------------------------------------------------
module dr_div_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [dr_pkg::DIV_W-1:0]      divisor,
    input  dr_pkg::cell_t                 cell_in,
    output dr_pkg::cell_t                 cell_out
);

    logic                       vld_reg;
    logic [dr_pkg::TGT_W-1:0]   word_reg;
    logic [dr_pkg::DIV_W-1:0]   rem_reg;
    dr_pkg::cell_t              cell_next;

    always_comb
    begin
        logic [dr_pkg::DIV_W:0]     trial;
        logic [dr_pkg::DIV_W-1:0]   r;
        logic [dr_pkg::TGT_W-1:0]   w;
        logic                       q;
        r = cell_in.rem;
        w = cell_in.word;
        for (int i = 0; i < dr_pkg::DIGIT_W; i++)
        begin
            trial = {r, w[dr_pkg::TGT_W-1]};
            q     = (trial >= {1'b0, divisor});
            if (q)
            begin
                trial = trial - {1'b0, divisor};
            end
            r = trial[dr_pkg::DIV_W-1:0];
            w = {w[dr_pkg::TGT_W-2:0], q};
        end
        cell_next.vld  = cell_in.vld;
        cell_next.word = w;
        cell_next.rem  = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= cell_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= cell_next.word;
            rem_reg  <= cell_next.rem;
        end
    end

    assign cell_out = {vld_reg, word_reg, rem_reg};

endmodule

### hdl/difficulty_retarget_compact_top.sv
// ----------------------------------------------------------------------------
// Compact difficulty retarget
// Retargets a compact proof-of-work target from a period's two timestamps.
// ----------------------------------------------------------------------------
// Usage: an input item on the s_axis channel carries the old compact bits and
// the start and end timestamps of one retarget period. One result item with
// the new compact bits leaves on the m_axis channel for every input item, in
// the same order. The cfg channel writes nominal_span (index 0) and
// limit_bits (index 1); it is always ready. The user must write it only
// while idle; the block itself does not enforce this. The block accepts
// one item per clock cycle while the output is not stalled. The item
// passes 37 registers: an input stage, a multiplier stage whose product is
// byte shifted on its way into the first cell, a chain of 32 divider cells
// that each yield eight quotient bits, a cap compare, a leading byte search
// and the output register. The first of them is loaded at the accepting edge.
// Reset clears every valid flag, so the pipeline comes up empty, and loads
// the config registers with their defaults. A receiver stall holds the
// whole pipeline and drops s_tready in the same cycle, so no item is lost.
// ----------------------------------------------------------------------------
module difficulty_retarget_compact_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // old_bits[31:0], period_start[63:32], period_end[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // next_bits[31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int TW = dr_pkg::TGT_W;

    logic [23:0]   nominal_span_reg;
    logic [31:0]   limit_bits_reg;
    logic [TW-1:0] lim_dec_reg;
    logic [TW-1:0] lim_dec_next;

    logic          adv;

    // Stage 0: clamped span and split target.
    logic          v0_reg;
    logic [22:0]   man0_reg,   man0_next;
    logic [25:0]   span0_reg,  span0_next;
    logic [4:0]    bsh0_reg,   bsh0_next;
    logic          zero0_reg,  zero0_next;

    // Stage 1: product.
    logic          v1_reg;
    logic [48:0]   prod1_reg;
    logic [4:0]    bsh1_reg;
    logic          zero1_reg;

    dr_pkg::cell_t chain [0:dr_pkg::NUM_CELLS];

    // Cap, search and output stages.
    logic          vc_reg;
    logic [TW-1:0] capv_reg;
    logic          ve_reg;
    logic [TW-1:0] encv_reg;
    logic [5:0]    size_reg, size_next;
    logic          out_vld_reg;
    logic [31:0]   out_bits_reg, out_bits_next;

    assign cfg_ready = 1'b1;
    assign adv       = !out_vld_reg || m_tready;
    assign s_tready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_span_reg <= dr_pkg::NOMINAL_SPAN_RST;
            limit_bits_reg   <= dr_pkg::LIMIT_BITS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dr_pkg::CFG_NOMINAL_SPAN: nominal_span_reg <= cfg_data[23:0];
                dr_pkg::CFG_LIMIT_BITS:   limit_bits_reg   <= cfg_data;
                default:                  nominal_span_reg <= nominal_span_reg;
            endcase
        end
    end

    // The decoded limit follows the register in the next cycle; it is only
    // read once an item has reached the cap stage.
    always_comb
    begin
        logic [7:0]  sz;
        logic [22:0] wd;
        logic [22:0] mn;
        sz = limit_bits_reg[31:24];
        wd = limit_bits_reg[22:0];
        if (sz == 8'd0)
        begin
            mn = 23'd0;
        end
        else if (sz == 8'd1)
        begin
            mn = wd >> 16;
        end
        else if (sz == 8'd2)
        begin
            mn = wd >> 8;
        end
        else
        begin
            mn = wd;
        end
        if (sz >= 8'd35)
        begin
            lim_dec_next = '0;
        end
        else if (sz > 8'd3)
        begin
            lim_dec_next = {{(TW-23){1'b0}}, mn} << {sz[4:0] - 5'd3, 3'b000};
        end
        else
        begin
            lim_dec_next = {{(TW-23){1'b0}}, mn};
        end
    end

    always_ff @(posedge clk)
    begin
        lim_dec_reg <= lim_dec_next;
    end

    // Timespan clamp and old target split into mantissa and byte shift.
    always_comb
    begin
        logic signed [33:0] diff;
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        logic signed [33:0] sp;
        logic [7:0]         sz;
        logic [22:0]        wd;
        diff = $signed({2'b00, s_tdata[95:64]}) - $signed({2'b00, s_tdata[63:32]});
        lo   = $signed({12'd0, nominal_span_reg[23:2]});
        hi   = $signed({8'd0, nominal_span_reg, 2'b00});
        sp   = diff;
        if (sp < lo)
        begin
            sp = lo;
        end
        if (sp > hi)
        begin
            sp = hi;
        end
        span0_next = sp[25:0];

        sz = s_tdata[31:24];
        wd = s_tdata[22:0];
        if (sz == 8'd0)
        begin
            man0_next = 23'd0;
        end
        else if (sz == 8'd1)
        begin
            man0_next = wd >> 16;
        end
        else if (sz == 8'd2)
        begin
            man0_next = wd >> 8;
        end
        else
        begin
            man0_next = wd;
        end
        bsh0_next  = (sz > 8'd3) ? (sz[4:0] - 5'd3) : 5'd0;
        zero0_next = (sz >= 8'd35);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            vc_reg      <= 1'b0;
            ve_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg      <= s_tvalid;
            v1_reg      <= v0_reg;
            vc_reg      <= chain[dr_pkg::NUM_CELLS].vld;
            ve_reg      <= vc_reg;
            out_vld_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            man0_reg  <= man0_next;
            span0_reg <= span0_next;
            bsh0_reg  <= bsh0_next;
            zero0_reg <= zero0_next;
            prod1_reg <= 49'(man0_reg) * 49'(span0_reg);
            bsh1_reg  <= bsh0_reg;
            zero1_reg <= zero0_reg;
        end
    end

    // Byte shift of the product forms the dividend fed to the first cell.
    always_comb
    begin
        chain[0].vld  = v1_reg;
        chain[0].rem  = '0;
        chain[0].word = zero1_reg ? '0
                      : ({{(TW-49){1'b0}}, prod1_reg} << {bsh1_reg, 3'b000});
    end

    for (genvar g = 0; g < dr_pkg::NUM_CELLS; g++)
    begin : g_cell
        dr_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .divisor  (nominal_span_reg),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    // Highest nonzero byte gives the compact size.
    always_comb
    begin
        size_next = 6'd0;
        for (int j = 0; j < TW / 8; j++)
        begin
            if (capv_reg[8*j +: 8] != 8'd0)
            begin
                size_next = 6'(j + 1);
            end
        end
    end

    always_comb
    begin
        logic [TW+23:0] ext;
        logic [23:0]    win;
        logic [7:0]     sz;
        ext = {encv_reg, 24'd0};
        win = ext[{size_reg, 3'b000} +: 24];
        sz  = {2'b00, size_reg};
        if (win[23])
        begin
            win = win >> 8;
            sz  = sz + 8'd1;
        end
        out_bits_next = {sz, win};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            capv_reg <= (chain[dr_pkg::NUM_CELLS].word > lim_dec_reg)
                      ? lim_dec_reg : chain[dr_pkg::NUM_CELLS].word;
            encv_reg     <= capv_reg;
            size_reg     <= size_next;
            out_bits_reg <= out_bits_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_bits_reg;

endmodule

### hdl/dr_checker.sv
// ----------------------------------------------------------------------------
// Retarget port checker
// Watches the top level's ports for handshake and result format slips.
// ----------------------------------------------------------------------------
`include "difficulty_retarget_compact_top_assert.svh"

module dr_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);

    `DR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `DR_ASSERT_NOW(a_ready_follows, clk, rst_n, m_tready, s_tready)
    `DR_ASSERT_NOW(a_sign_clear, clk, rst_n, m_tvalid, !m_tdata[23])
    `DR_ASSERT_NOW(a_size_range, clk, rst_n, m_tvalid, m_tdata[31:24] <= 8'd33)

endmodule

bind difficulty_retarget_compact_top dr_checker u_dr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
